// ===== hdl/rrdf_pkg.sv =====
// Shared types, constants and codes for the route request duplicate filter.
package rrdf_pkg;

  // Table geometry
  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  // Reset value of the idle limit register (ms)
  localparam logic [31:0] IdleReset = 32'd10000;

  // Result codes
  typedef enum logic [2:0] {
    OUT_INSERTED       = 3'd0,
    OUT_SEQ_UPDATED    = 3'd1,
    OUT_METRIC_UPDATED = 3'd2,
    OUT_REDUNDANT      = 3'd3,
    OUT_FULL           = 3'd4
  } outcome_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  // One table entry (also used to hold the request being processed)
  typedef struct packed {
    logic [63:0] orig_hi;
    logic [63:0] orig_lo;
    logic [63:0] targ_hi;
    logic [63:0] targ_lo;
    logic [7:0]  metric_type;
    logic [7:0]  metric;
    logic [15:0] seqnum;
    logic [31:0] stamp;
  } entry_t;

  // Write controls into the entry store, per field group
  typedef struct packed {
    logic            key_we;
    logic            metric_we;
    logic            seq_we;
    logic            time_we;
    logic [IdxW-1:0] idx;
  } wr_ctl_t;

  // Per-entry verdict of the compare unit
  typedef struct packed {
    logic stale;
    logic hit;
    logic free;
  } cmp_res_t;

endpackage

// ===== hdl/rrdf_store.sv =====
// Entry data memory: per-field-group write enables, one registered read port.
module rrdf_store (
  input  logic                        clk_i,
  input  rrdf_pkg::wr_ctl_t           wr_i,
  input  rrdf_pkg::entry_t            wdata_i,
  input  logic [rrdf_pkg::IdxW-1:0]   raddr_i,
  output rrdf_pkg::entry_t            rdata_o
);
  import rrdf_pkg::*;

  logic [63:0] orig_hi_mem [TableEntries];
  logic [63:0] orig_lo_mem [TableEntries];
  logic [63:0] targ_hi_mem [TableEntries];
  logic [63:0] targ_lo_mem [TableEntries];
  logic [7:0]  mtype_mem   [TableEntries];
  logic [7:0]  metric_mem  [TableEntries];
  logic [15:0] seq_mem     [TableEntries];
  logic [31:0] time_mem    [TableEntries];

  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) begin
      orig_hi_mem[wr_i.idx] <= wdata_i.orig_hi;
      orig_lo_mem[wr_i.idx] <= wdata_i.orig_lo;
      targ_hi_mem[wr_i.idx] <= wdata_i.targ_hi;
      targ_lo_mem[wr_i.idx] <= wdata_i.targ_lo;
      mtype_mem[wr_i.idx]   <= wdata_i.metric_type;
    end
    if (wr_i.metric_we) begin
      metric_mem[wr_i.idx] <= wdata_i.metric;
    end
    if (wr_i.seq_we) begin
      seq_mem[wr_i.idx] <= wdata_i.seqnum;
    end
    if (wr_i.time_we) begin
      time_mem[wr_i.idx] <= wdata_i.stamp;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q.orig_hi     <= orig_hi_mem[raddr_i];
    rdata_q.orig_lo     <= orig_lo_mem[raddr_i];
    rdata_q.targ_hi     <= targ_hi_mem[raddr_i];
    rdata_q.targ_lo     <= targ_lo_mem[raddr_i];
    rdata_q.metric_type <= mtype_mem[raddr_i];
    rdata_q.metric      <= metric_mem[raddr_i];
    rdata_q.seqnum      <= seq_mem[raddr_i];
    rdata_q.stamp       <= time_mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rrdf_cmp.sv =====
// Shared per-entry compare unit: expiry check, key match and free test.
module rrdf_cmp (
  input  logic               valid_i,
  input  rrdf_pkg::entry_t   entry_i,
  input  rrdf_pkg::entry_t   req_i,
  input  logic [31:0]        now_i,
  input  logic [31:0]        max_idle_i,
  output rrdf_pkg::cmp_res_t res_o
);
  import rrdf_pkg::*;

  logic [32:0] expiry;
  logic        key_eq;

  // Expiry sum keeps its carry, so it never wraps
  assign expiry = {1'b0, entry_i.stamp} + {1'b0, max_idle_i};

  assign key_eq = (entry_i.orig_hi == req_i.orig_hi) &&
                  (entry_i.orig_lo == req_i.orig_lo) &&
                  (entry_i.targ_hi == req_i.targ_hi) &&
                  (entry_i.targ_lo == req_i.targ_lo) &&
                  (entry_i.metric_type == req_i.metric_type);

  // An aged-out entry counts as free and never matches
  always_comb begin
    res_o.stale = valid_i && (expiry < {1'b0, now_i});
    res_o.hit   = valid_i && !res_o.stale && key_eq;
    res_o.free  = !valid_i || res_o.stale;
  end

endmodule

// ===== hdl/route_request_duplicate_filter_core.sv =====
// Top level: request sequencer, valid bits, decision logic and result register.
// One word is processed at a time: input is accepted only when the sequencer is idle, and
// the scan reads one entry per cycle through the single read port of the entry store and
// one shared compare unit.
// Reset (rst_ni low, async): all entries invalid, idle limit 10000 ms, no result pending.
// Entry data is not cleared by reset; it is only read behind a set valid bit.
module route_request_duplicate_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] orig_addr_hi_i,
  input  logic [63:0] orig_addr_lo_i,
  input  logic [63:0] targ_addr_hi_i,
  input  logic [63:0] targ_addr_lo_i,
  input  logic [7:0]  metric_type_i,
  input  logic [7:0]  route_metric_i,
  input  logic [15:0] sequence_number_i,
  input  logic [31:0] now_time_i,
  input  logic [31:0] arrival_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        redundant_o,
  output logic [2:0]  outcome_o
);
  import rrdf_pkg::*;

  state_e            state_q, state_d;
  logic [31:0]       max_idle_q;
  logic [TableEntries-1:0] valid_q, valid_d;

  entry_t            req_q;
  logic [31:0]       now_q;

  logic [CntW-1:0]   scan_q, scan_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]   chk_idx_q;

  logic              hit_q, hit_d;
  logic [IdxW-1:0]   hit_idx_q, hit_idx_d;
  logic [15:0]       hit_seq_q, hit_seq_d;
  logic [7:0]        hit_metric_q, hit_metric_d;
  logic              free_q, free_d;
  logic [IdxW-1:0]   free_idx_q, free_idx_d;

  logic              out_valid_q, out_valid_d;
  logic              red_q;
  outcome_e          outcome_q, outcome_d;
  logic              red_d;

  logic              accept;
  logic              scan_en;
  logic              scan_issue;
  logic              scan_last;
  logic              decide_fire;
  logic [15:0]       seq_diff;

  entry_t            rd_entry;
  entry_t            wdata;
  wr_ctl_t           wr;
  cmp_res_t          cmp;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_idle_q <= IdleReset;
    end else if (cfg_we_i) begin
      max_idle_q <= cfg_wdata_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (scan_last) state_d = ST_DECIDE;
      ST_DECIDE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o  = 1'b0;
    scan_en     = 1'b0;
    decide_fire = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o  = 1'b1;
      ST_SCAN:   scan_en     = 1'b1;
      ST_DECIDE: decide_fire = !out_valid_q || out_ready_i;
      default:   ;
    endcase
  end

  assign accept     = in_valid_i && in_ready_o;
  assign scan_issue = scan_en && (scan_q < CntW'(TableEntries));
  assign scan_last  = scan_en && !scan_issue && chk_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.orig_hi     <= orig_addr_hi_i;
      req_q.orig_lo     <= orig_addr_lo_i;
      req_q.targ_hi     <= targ_addr_hi_i;
      req_q.targ_lo     <= targ_addr_lo_i;
      req_q.metric_type <= metric_type_i;
      req_q.metric      <= route_metric_i;
      req_q.seqnum      <= sequence_number_i;
      req_q.stamp       <= arrival_time_i;
      now_q             <= now_time_i;
    end
  end

  // Scan address counter; read data arrives in the next cycle
  always_comb begin
    scan_d    = scan_q;
    chk_vld_d = 1'b0;
    if (accept) begin
      scan_d = '0;
    end else if (scan_issue) begin
      scan_d    = scan_q + CntW'(1);
      chk_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      scan_q    <= scan_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= scan_q[IdxW-1:0];
  end

  rrdf_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .wdata_i (wdata),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  rrdf_cmp u_cmp (
    .valid_i    (valid_q[chk_idx_q]),
    .entry_i    (rd_entry),
    .req_i      (req_q),
    .now_i      (now_q),
    .max_idle_i (max_idle_q),
    .res_o      (cmp)
  );

  // Record lowest match and lowest free entry
  always_comb begin
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_seq_d    = hit_seq_q;
    hit_metric_d = hit_metric_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    if (accept) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else if (chk_vld_q) begin
      if (cmp.hit && !hit_q) begin
        hit_d        = 1'b1;
        hit_idx_d    = chk_idx_q;
        hit_seq_d    = rd_entry.seqnum;
        hit_metric_d = rd_entry.metric;
      end
      if (cmp.free && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = chk_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      hit_q  <= hit_d;
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q    <= hit_idx_d;
    hit_seq_q    <= hit_seq_d;
    hit_metric_q <= hit_metric_d;
    free_idx_q   <= free_idx_d;
  end

  // Decision and write-back
  assign seq_diff = req_q.seqnum - hit_seq_q;

  always_comb begin
    outcome_d     = OUT_FULL;
    red_d         = 1'b0;
    wr            = '0;
    wdata         = req_q;
    wdata.stamp   = now_q;
    if (!hit_q) begin
      if (free_q) begin
        outcome_d    = OUT_INSERTED;
        wdata.stamp  = req_q.stamp;
        wr.key_we    = decide_fire;
        wr.metric_we = decide_fire;
        wr.seq_we    = decide_fire;
        wr.time_we   = decide_fire;
      end
      wr.idx = free_idx_q;
    end else begin
      wr.idx = hit_idx_q;
      if (seq_diff == 16'd0) begin
        if (hit_metric_q <= req_q.metric) begin
          outcome_d = OUT_REDUNDANT;
          red_d     = 1'b1;
        end else begin
          outcome_d    = OUT_METRIC_UPDATED;
          wr.metric_we = decide_fire;
          wr.time_we   = decide_fire;
        end
      end else if (seq_diff[15]) begin
        // older, including the half-range distance
        outcome_d = OUT_REDUNDANT;
        red_d     = 1'b1;
      end else begin
        outcome_d  = OUT_SEQ_UPDATED;
        wr.seq_we  = decide_fire;
        wr.time_we = decide_fire;
      end
    end
  end

  // Valid bits: aging clears during the scan, insertion sets
  always_comb begin
    valid_d = valid_q;
    if (chk_vld_q && cmp.stale) begin
      valid_d[chk_idx_q] = 1'b0;
    end
    if (decide_fire && !hit_q && free_q) begin
      valid_d[free_idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result register
  assign out_valid_d = decide_fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (decide_fire) begin
      red_q     <= red_d;
      outcome_q <= outcome_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign redundant_o = red_q;
  assign outcome_o   = outcome_q;

  // Checks
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN) && (scan_q == '0))
    else $error("accepted word did not start a scan");

  a_idle_no_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !chk_vld_q)
    else $error("entry check pending while idle");

  a_redundant_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (redundant_o == (outcome_o == OUT_REDUNDANT)))
    else $error("redundant flag disagrees with outcome");

  a_insert_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (decide_fire && !hit_q && free_q) |=> valid_q[$past(free_idx_q)])
    else $error("inserted entry not marked valid");

  a_hit_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && hit_q) |-> valid_q[hit_idx_q])
    else $error("matched entry is not valid");

endmodule
